// File: src/radix_integer_text_parser_macros.svh
// assertion macros used by the parser rtl
`ifndef RADIX_INTEGER_TEXT_PARSER_MACROS_SVH
`define RADIX_INTEGER_TEXT_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rtp_pkg.sv
// types and constants of the radix integer text parser
`timescale 1ns / 1ps

package rtp_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_START,
    PH_A_PREFIX,
    PH_A_ZERO,
    PH_A_BODY,
    PH_F_BODY,
    PH_ERROR
  } phase_t;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // configuration register indexes
  localparam logic CFG_AUTO_RADIX = 1'b0;
  localparam logic CFG_RADIX      = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  // radix values
  localparam logic [5:0] RADIX_HEX   = 6'd16;
  localparam logic [5:0] RADIX_OCT   = 6'd8;
  localparam logic [5:0] RADIX_DEC   = 6'd10;
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;

  // magnitude limits
  localparam logic [63:0] MAG_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAG_NEG_LIMIT = 64'h8000_0000_0000_0000;

  // classified character item
  typedef struct packed {
    logic [5:0] dval;
    logic       is_digit;
    logic       is_minus;
    logic       is_plus;
    logic       is_hash;
    logic       is_zero;
    logic       is_x;
    logic       last;
    logic       empty;
  } tok_t;

endpackage

// File: src/rtp_channels.sv
// handshake channels for characters in and results out
`timescale 1ns / 1ps

interface rtp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  logic       empty_req;

  modport source (output valid, output ch, output last, output empty_req, input ready);
  modport sink (input valid, input ch, input last, input empty_req, output ready);
endinterface

interface rtp_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// File: src/rtp_front.sv
// front part: takes characters and classifies them into items for the queue
`timescale 1ns / 1ps

module rtp_front (
  rtp_char_if.sink    chars,
  input  logic        full,
  output logic        push,
  output rtp_pkg::tok_t tok
);

  logic [7:0] off;
  logic       is_dig;

  // handshake toward the character source
  assign chars.ready = !full;
  assign push        = chars.valid && !full;

  // digit value of letters and numerals
  always_comb begin
    off    = 8'd0;
    is_dig = 1'b0;
    if (chars.ch >= rtp_pkg::CH_ZERO && chars.ch <= rtp_pkg::CH_NINE) begin
      off    = chars.ch - rtp_pkg::CH_ZERO;
      is_dig = 1'b1;
    end else if (chars.ch >= rtp_pkg::CH_LA && chars.ch <= rtp_pkg::CH_LZ) begin
      off    = chars.ch - rtp_pkg::CH_LA + 8'd10;
      is_dig = 1'b1;
    end else if (chars.ch >= rtp_pkg::CH_UA && chars.ch <= rtp_pkg::CH_UZ) begin
      off    = chars.ch - rtp_pkg::CH_UA + 8'd10;
      is_dig = 1'b1;
    end
  end

  // character classes for sign and prefix handling
  assign tok.is_digit = is_dig;
  assign tok.dval     = off[5:0];
  assign tok.is_minus = chars.ch == rtp_pkg::CH_MINUS;
  assign tok.is_plus  = chars.ch == rtp_pkg::CH_PLUS;
  assign tok.is_hash  = chars.ch == rtp_pkg::CH_HASH;
  assign tok.is_zero  = chars.ch == rtp_pkg::CH_ZERO;
  assign tok.is_x     = chars.ch == rtp_pkg::CH_LX || chars.ch == rtp_pkg::CH_UX;
  assign tok.last     = chars.last;
  assign tok.empty    = chars.empty_req;

endmodule

// File: src/rtp_queue.sv
// short item queue between the front and back parts
`timescale 1ns / 1ps

module rtp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rtp_pkg::tok_t wr_tok,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rtp_pkg::tok_t head_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rtp_pkg::tok_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_tok   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/rtp_back.sv
// back part: sign, prefix and digit accumulation, with the result register
`timescale 1ns / 1ps
`include "radix_integer_text_parser_macros.svh"

module rtp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           auto_radix,
  input  logic [5:0]     radix,
  input  logic           head_valid,
  input  rtp_pkg::tok_t  tok,
  output logic           pop,
  rtp_result_if.source   results
);

  rtp_pkg::phase_t phase, phase_next, ph_step;
  logic [63:0] acc, acc_next, acc_s;
  logic        neg, neg_next, neg_s;
  logic [5:0]  aradix, aradix_next, radix_s;
  logic [1:0]  err, err_next, err_s;
  logic        seen, seen_next, seen_s;

  logic        out_valid;
  logic [63:0] out_mag, res_mag;
  logic        out_neg, res_neg;
  logic [1:0]  out_status, res_status;

  logic        done;
  logic        radix_ok;
  logic        try_digit;
  logic [5:0]  radix_use;
  logic        bad;
  logic [69:0] prod;
  logic [63:0] lim;
  logic        dig_mal, dig_ovf, dig_take, dig_fail;
  logic        prefix_zero;

  // item handshake with the queue and the result register
  assign pop      = head_valid && (!out_valid || results.ready);
  assign done     = tok.last || tok.empty;
  assign radix_ok = radix >= rtp_pkg::RADIX_MIN && radix <= rtp_pkg::RADIX_MAX;
  assign prefix_zero = tok.is_zero && !tok.last;

  // which radix a digit of this item is checked against
  always_comb begin
    try_digit = 1'b0;
    radix_use = aradix;
    unique case (phase)
      rtp_pkg::PH_START: begin
        if (auto_radix) begin
          try_digit = !tok.is_minus && !tok.is_plus && !tok.is_hash && !prefix_zero;
          radix_use = rtp_pkg::RADIX_DEC;
        end else begin
          try_digit = radix_ok && !tok.is_minus && !tok.is_plus;
          radix_use = radix;
        end
      end
      rtp_pkg::PH_A_PREFIX: begin
        try_digit = !tok.is_minus && !tok.is_plus && !tok.is_hash && !prefix_zero;
        radix_use = rtp_pkg::RADIX_DEC;
      end
      rtp_pkg::PH_A_ZERO: begin
        try_digit = !tok.is_x;
        radix_use = rtp_pkg::RADIX_OCT;
      end
      rtp_pkg::PH_A_BODY, rtp_pkg::PH_F_BODY: begin
        try_digit = 1'b1;
        radix_use = aradix;
      end
      default: begin
        try_digit = 1'b0;
        radix_use = aradix;
      end
    endcase
  end

  // multiply-add with exact overflow compare against the magnitude limit
  assign bad  = !tok.is_digit || tok.dval >= radix_use;
  assign prod = 70'(acc) * 70'(radix_use) + 70'(tok.dval);
  assign lim  = (phase == rtp_pkg::PH_F_BODY && neg) ? rtp_pkg::MAG_NEG_LIMIT
                                                     : rtp_pkg::MAG_POS_LIMIT;
  assign dig_mal  = try_digit && bad;
  assign dig_ovf  = try_digit && !bad && (prod > {6'd0, lim});
  assign dig_take = try_digit && !bad && !dig_ovf;
  assign dig_fail = dig_mal || dig_ovf;

  // next phase
  always_comb begin
    ph_step = phase;
    unique case (phase)
      rtp_pkg::PH_START: begin
        if (auto_radix) begin
          priority if (tok.is_minus || tok.is_plus) ph_step = rtp_pkg::PH_A_PREFIX;
          else if (tok.is_hash) ph_step = rtp_pkg::PH_A_BODY;
          else if (prefix_zero) ph_step = rtp_pkg::PH_A_ZERO;
          else ph_step = dig_fail ? rtp_pkg::PH_ERROR : rtp_pkg::PH_A_BODY;
        end else begin
          priority if (!radix_ok) ph_step = rtp_pkg::PH_ERROR;
          else if (tok.is_minus || tok.is_plus) ph_step = rtp_pkg::PH_F_BODY;
          else ph_step = dig_fail ? rtp_pkg::PH_ERROR : rtp_pkg::PH_F_BODY;
        end
      end
      rtp_pkg::PH_A_PREFIX: begin
        priority if (tok.is_hash) ph_step = rtp_pkg::PH_A_BODY;
        else if (prefix_zero) ph_step = rtp_pkg::PH_A_ZERO;
        else if (tok.is_minus || tok.is_plus) ph_step = rtp_pkg::PH_ERROR;
        else ph_step = dig_fail ? rtp_pkg::PH_ERROR : rtp_pkg::PH_A_BODY;
      end
      rtp_pkg::PH_A_ZERO: begin
        if (tok.is_x) ph_step = rtp_pkg::PH_A_BODY;
        else ph_step = dig_fail ? rtp_pkg::PH_ERROR : rtp_pkg::PH_A_BODY;
      end
      rtp_pkg::PH_A_BODY, rtp_pkg::PH_F_BODY: begin
        ph_step = dig_fail ? rtp_pkg::PH_ERROR : phase;
      end
      default: begin
        ph_step = rtp_pkg::PH_ERROR;
      end
    endcase
    if (!pop) phase_next = phase;
    else if (done) phase_next = rtp_pkg::PH_START;
    else phase_next = ph_step;
  end

  // parse state and result outputs
  always_comb begin
    acc_s   = dig_take ? prod[63:0] : acc;
    seen_s  = seen || dig_take;
    neg_s   = neg;
    radix_s = aradix;
    err_s   = err;
    if (phase == rtp_pkg::PH_START && tok.is_minus && (auto_radix || radix_ok)) begin
      neg_s = 1'b1;
    end
    unique case (phase)
      rtp_pkg::PH_START: begin
        if (!auto_radix) radix_s = radix;
        else if (tok.is_hash) radix_s = rtp_pkg::RADIX_HEX;
        else if (try_digit) radix_s = rtp_pkg::RADIX_DEC;
      end
      rtp_pkg::PH_A_PREFIX: begin
        if (tok.is_hash) radix_s = rtp_pkg::RADIX_HEX;
        else if (try_digit) radix_s = rtp_pkg::RADIX_DEC;
      end
      rtp_pkg::PH_A_ZERO: begin
        radix_s = tok.is_x ? rtp_pkg::RADIX_HEX : rtp_pkg::RADIX_OCT;
      end
      default: begin
        radix_s = aradix;
      end
    endcase
    // first error keeps its code
    if (phase != rtp_pkg::PH_ERROR && ph_step == rtp_pkg::PH_ERROR) begin
      err_s = dig_ovf ? rtp_pkg::ST_OVERFLOW : rtp_pkg::ST_MALFORMED;
    end

    // result of an item that ends the string
    res_mag = '1;
    res_neg = 1'b0;
    priority if (tok.empty) begin
      res_status = rtp_pkg::ST_EMPTY;
    end else if (ph_step == rtp_pkg::PH_ERROR) begin
      res_status = err_s;
    end else if ((ph_step == rtp_pkg::PH_A_BODY || ph_step == rtp_pkg::PH_F_BODY) && seen_s) begin
      res_status = rtp_pkg::ST_OK;
      res_mag    = acc_s;
      res_neg    = neg_s;
    end else begin
      res_status = rtp_pkg::ST_MALFORMED;
    end

    // state after this item
    acc_next    = acc;
    neg_next    = neg;
    aradix_next = aradix;
    err_next    = err;
    seen_next   = seen;
    if (pop) begin
      if (done) begin
        acc_next    = '0;
        neg_next    = 1'b0;
        aradix_next = rtp_pkg::RADIX_DEC;
        err_next    = rtp_pkg::ST_OK;
        seen_next   = 1'b0;
      end else begin
        acc_next    = acc_s;
        neg_next    = neg_s;
        aradix_next = radix_s;
        err_next    = err_s;
        seen_next   = seen_s;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= rtp_pkg::PH_START;
      acc    <= '0;
      neg    <= 1'b0;
      aradix <= rtp_pkg::RADIX_DEC;
      err    <= rtp_pkg::ST_OK;
      seen   <= 1'b0;
    end else begin
      phase  <= phase_next;
      acc    <= acc_next;
      neg    <= neg_next;
      aradix <= aradix_next;
      err    <= err_next;
      seen   <= seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && done) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && done) begin
      out_mag    <= res_mag;
      out_neg    <= res_neg;
      out_status <= res_status;
    end
  end

  // sign applied on the way out
  assign results.valid  = out_valid;
  assign results.status = out_status;
  assign results.value  = $signed(out_neg ? (64'd0 - out_mag) : out_mag);

  `RTP_ASSERT_IMP(a_err_value, out_valid && out_status != rtp_pkg::ST_OK, out_mag == '1 && !out_neg, "error result without all-ones value")
  `RTP_ASSERT_NXT(a_clear_after, pop && done, phase == rtp_pkg::PH_START && acc == '0 && !seen, "parse state not cleared after a result")
  `RTP_ASSERT_IMP(a_err_code, phase == rtp_pkg::PH_ERROR, err == rtp_pkg::ST_MALFORMED || err == rtp_pkg::ST_OVERFLOW, "error phase without error code")
  `RTP_ASSERT_IMP(a_acc_bound, acc[63], acc[62:0] == '0, "accumulator beyond the negative limit")
  `RTP_ASSERT_IMP(a_no_digit, !seen, acc == '0, "accumulator set without a digit")

endmodule

// File: src/radix_integer_text_parser.sv
// top level of the radix integer text parser
`timescale 1ns / 1ps

// Parses one number text per string, one character per item, and returns a
// signed 64-bit value with a status on the item that ends the string (or on
// an empty request). The block sustains one character per clock cycle while
// the result register is free; that figure is set by the back part's
// accumulator loop, which does one multiply by the radix, one add of the
// digit and one exact compare against the magnitude limit per cycle. The
// last character of a string is written into the item queue when accepted
// and, once it heads the queue and the result register is free, the back
// part registers the result. While a result waits in the result register
// the back part takes no further characters; they collect in the item
// queue (QUEUE_DEPTH deep) and the input stalls once it is full.
// Configuration sets fixed radix or prefix detection and is sampled on the
// first character of each string.
module radix_integer_text_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  rtp_char_if.sink     chars,
  rtp_result_if.source results,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [5:0]   cfg_data
);

  logic          auto_radix;
  logic [5:0]    radix;
  logic          push, full, pop, head_valid;
  rtp_pkg::tok_t wr_tok, head_tok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_radix <= 1'b0;
      radix      <= rtp_pkg::RADIX_DEC;
    end else if (cfg_we) begin
      unique case (cfg_index[0])
        rtp_pkg::CFG_AUTO_RADIX: auto_radix <= cfg_data[0];
        rtp_pkg::CFG_RADIX:      radix      <= cfg_data;
        default:                 radix      <= radix;
      endcase
    end
  end

  // classify incoming characters
  rtp_front u_front (
    .chars (chars),
    .full  (full),
    .push  (push),
    .tok   (wr_tok)
  );

  // decouple front and back
  rtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_tok     (wr_tok),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  // accumulate and report
  rtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .auto_radix (auto_radix),
    .radix      (radix),
    .head_valid (head_valid),
    .tok        (head_tok),
    .pop        (pop),
    .results    (results)
  );

endmodule
